@@ sv/pbcg_pkg.sv @@
// shared types and constants for the pixel blend and colour grade unit
`timescale 1ns / 1ps
`default_nettype none

package pbcg_pkg;

  // blend mode codes
  localparam logic [2:0] MODE_ALPHA = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_MUL   = 3'd2;
  localparam logic [2:0] MODE_SCR   = 3'd3;
  localparam logic [2:0] MODE_MAX   = 3'd4;
  localparam logic [2:0] MODE_PASS  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_BLEND_MODE   = 3'd0;
  localparam logic [2:0] REG_BLEND_FACTOR = 3'd1;
  localparam logic [2:0] REG_SAT_GAIN     = 3'd2;
  localparam logic [2:0] REG_BRIGHT_GAIN  = 3'd3;
  localparam logic [2:0] REG_TINT_RED     = 3'd4;
  localparam logic [2:0] REG_TINT_GREEN   = 3'd5;
  localparam logic [2:0] REG_TINT_BLUE    = 3'd6;

  localparam logic [16:0] FACTOR_ONE = 17'h10000;
  localparam logic [15:0] GAIN_ONE   = 16'd4096;

  // rec.709 luma weights scaled by ten thousand
  localparam int LUM_W_RED   = 2126;
  localparam int LUM_W_GREEN = 7152;
  localparam int LUM_W_BLUE  = 722;
  localparam int LUM_SCALE   = 10000;

  // reciprocals for division by constants
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int          DIV255_SHIFT = 23;
  localparam logic [22:0] LQ_RECIP     = 23'd6871948;
  localparam int          LQ_SHIFT     = 36;
  localparam logic [30:0] FRAC_RECIP   = 31'd1759218605;
  localparam int          FRAC_SHIFT   = 44;

  typedef struct packed {
    logic [2:0]  mode;
    logic [16:0] factor;
    logic [16:0] inv;
  } blend_cfg_t;

  typedef struct packed {
    logic [15:0] sat_gain;
    logic [15:0] bright_gain;
  } grade_cfg_t;

endpackage

`default_nettype wire

@@ sv/pixel_blend_color_grade_unit.sv @@
// top level of the pixel blend and colour grade unit
//
//   channel   ports                                   handshake
//   config    psel penable pwrite paddr pwdata prdata  apb write, pready tied high
//   pixel in  cur_* fb_*                              start while busy is low
//   pixel out out_*                                   done strobe, one cycle
//
// one pixel is accepted every clock; busy never rises
// a beat passes through the blend lanes, then the luma merge, then the grade lanes
// the grade lanes set the depth through their chain of gain multipliers
// rst clears the beat pipeline and loads the register reset values
// the result strobe cannot be held off, so nothing in the pipeline ever stalls
`timescale 1ns / 1ps
`default_nettype none

module pixel_blend_color_grade_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  cur_red,
  input  wire logic [7:0]  cur_green,
  input  wire logic [7:0]  cur_blue,
  input  wire logic [7:0]  cur_alpha,
  input  wire logic [7:0]  fb_red,
  input  wire logic [7:0]  fb_green,
  input  wire logic [7:0]  fb_blue,
  input  wire logic [7:0]  fb_alpha,
  output logic             done,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue,
  output logic      [7:0]  out_alpha
);

  localparam int PIPE_DEPTH  = 11;
  localparam int ALPHA_DELAY = 8;

  logic [2:0]  blend_mode;
  logic [16:0] blend_factor;
  logic [15:0] saturation_gain;
  logic [15:0] brightness_gain;
  logic [15:0] tint_red;
  logic [15:0] tint_green;
  logic [15:0] tint_blue;

  logic        wr;
  logic [2:0]  reg_idx;

  logic [16:0]          factor;
  pbcg_pkg::blend_cfg_t colour_cfg;
  pbcg_pkg::blend_cfg_t alpha_cfg;
  pbcg_pkg::grade_cfg_t grade_cfg;
  logic [7:0]           alpha_src;

  logic [2:0][7:0] cur_rgb;
  logic [2:0][7:0] fb_rgb;
  logic [2:0][7:0] blended;
  logic [2:0][7:0] merged;
  logic [2:0][15:0] tints;
  logic [2:0][7:0] graded;
  logic [7:0]      alpha_blended;
  logic [7:0]      lq;
  logic [13:0]     lr;

  logic [PIPE_DEPTH-1:0]       vld;
  logic [ALPHA_DELAY-1:0][7:0] alpha_pipe;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode      <= pbcg_pkg::MODE_ALPHA;
      blend_factor    <= 17'd0;
      saturation_gain <= pbcg_pkg::GAIN_ONE;
      brightness_gain <= pbcg_pkg::GAIN_ONE;
      tint_red        <= pbcg_pkg::GAIN_ONE;
      tint_green      <= pbcg_pkg::GAIN_ONE;
      tint_blue       <= pbcg_pkg::GAIN_ONE;
    end else if (wr) begin
      unique case (reg_idx)
        pbcg_pkg::REG_BLEND_MODE:   blend_mode      <= pwdata[2:0];
        pbcg_pkg::REG_BLEND_FACTOR: blend_factor    <= pwdata[16:0];
        pbcg_pkg::REG_SAT_GAIN:     saturation_gain <= pwdata[15:0];
        pbcg_pkg::REG_BRIGHT_GAIN:  brightness_gain <= pwdata[15:0];
        pbcg_pkg::REG_TINT_RED:     tint_red        <= pwdata[15:0];
        pbcg_pkg::REG_TINT_GREEN:   tint_green      <= pwdata[15:0];
        pbcg_pkg::REG_TINT_BLUE:    tint_blue       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pbcg_pkg::REG_BLEND_MODE:   prdata = {29'd0, blend_mode};
      pbcg_pkg::REG_BLEND_FACTOR: prdata = {15'd0, blend_factor};
      pbcg_pkg::REG_SAT_GAIN:     prdata = {16'd0, saturation_gain};
      pbcg_pkg::REG_BRIGHT_GAIN:  prdata = {16'd0, brightness_gain};
      pbcg_pkg::REG_TINT_RED:     prdata = {16'd0, tint_red};
      pbcg_pkg::REG_TINT_GREEN:   prdata = {16'd0, tint_green};
      pbcg_pkg::REG_TINT_BLUE:    prdata = {16'd0, tint_blue};
      default:                    prdata = 32'd0;
    endcase
  end

  // factor above one saturates
  assign factor = blend_factor[16] ? pbcg_pkg::FACTOR_ONE : blend_factor;

  assign colour_cfg.mode   = blend_mode;
  assign colour_cfg.factor = factor;
  assign colour_cfg.inv    = pbcg_pkg::FACTOR_ONE - factor;

  // alpha rides a fourth lane with the mode mapped onto lerp or pass
  always_comb begin
    alpha_cfg = colour_cfg;
    alpha_src = cur_alpha;
    priority if (blend_mode == pbcg_pkg::MODE_ALPHA) begin
      alpha_cfg.mode = pbcg_pkg::MODE_ALPHA;
    end else if (blend_mode == pbcg_pkg::MODE_ADD || blend_mode == pbcg_pkg::MODE_MAX) begin
      alpha_cfg.mode = pbcg_pkg::MODE_PASS;
      alpha_src      = (cur_alpha > fb_alpha) ? cur_alpha : fb_alpha;
    end else begin
      alpha_cfg.mode = pbcg_pkg::MODE_PASS;
    end
  end

  assign grade_cfg.sat_gain    = saturation_gain;
  assign grade_cfg.bright_gain = brightness_gain;

  assign cur_rgb = {cur_blue, cur_green, cur_red};
  assign fb_rgb  = {fb_blue, fb_green, fb_red};
  assign tints   = {tint_blue, tint_green, tint_red};

  for (genvar i = 0; i < 3; i++) begin : g_blend
    pbcg_blend_lane u_lane (
      .clk     (clk),
      .cfg     (colour_cfg),
      .cur     (cur_rgb[i]),
      .fb      (fb_rgb[i]),
      .blended (blended[i])
    );
  end

  pbcg_blend_lane u_alpha_lane (
    .clk     (clk),
    .cfg     (alpha_cfg),
    .cur     (alpha_src),
    .fb      (fb_alpha),
    .blended (alpha_blended)
  );

  pbcg_luma_merge u_merge (
    .clk        (clk),
    .colour_in  (blended),
    .lq         (lq),
    .lr         (lr),
    .colour_out (merged)
  );

  for (genvar i = 0; i < 3; i++) begin : g_grade
    pbcg_grade_lane u_lane (
      .clk    (clk),
      .cfg    (grade_cfg),
      .tint   (tints[i]),
      .colour (merged[i]),
      .lq     (lq),
      .lr     (lr),
      .graded (graded[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    alpha_pipe <= {alpha_pipe[ALPHA_DELAY-2:0], alpha_blended};
  end

  assign done      = vld[PIPE_DEPTH-1];
  assign out_red   = graded[0];
  assign out_green = graded[1];
  assign out_blue  = graded[2];
  assign out_alpha = alpha_pipe[ALPHA_DELAY-1];

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##11 done)
    else $error("accepted beat did not reach the output");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 11))
    else $error("result strobe without an accepted beat");

  a_pass_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && blend_mode == pbcg_pkg::MODE_PASS) |-> out_alpha == $past(cur_alpha, 11))
    else $error("pass mode altered alpha");

  a_max_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && (blend_mode == pbcg_pkg::MODE_ADD || blend_mode == pbcg_pkg::MODE_MAX))
      |-> out_alpha >= $past(cur_alpha, 11))
    else $error("max alpha below current alpha");

  a_dark: assert property (@(posedge clk) disable iff (rst)
    (done && brightness_gain == 16'd0) |-> (out_red == 8'd0 && out_green == 8'd0
      && out_blue == 8'd0))
    else $error("zero brightness left colour");

endmodule

`default_nettype wire

@@ sv/pbcg_blend_lane.sv @@
// one blend lane: mixes a current and a feedback channel under the blend mode
`timescale 1ns / 1ps
`default_nettype none

module pbcg_blend_lane (
  input  wire logic                 clk,
  input  wire pbcg_pkg::blend_cfg_t cfg,
  input  wire logic [7:0]           cur,
  input  wire logic [7:0]           fb,
  output logic      [7:0]           blended
);

  logic [7:0]  mx;
  logic [24:0] p_si;
  logic [24:0] p_df;
  logic [24:0] p_mf;
  logic [15:0] sd;
  logic [15:0] scr;
  logic [7:0]  s1;
  logic [2:0]  mode1;

  logic [24:0] sum_a;
  logic [24:0] sum_m;
  logic [15:0] opnd;
  logic [31:0] wide;
  logic [8:0]  v_next;
  logic        div_next;
  logic [8:0]  v2;
  logic [15:0] n2;
  logic        div2;

  logic [31:0] q_prod;
  logic [8:0]  q;

  assign mx = (cur > fb) ? cur : fb;

  always_ff @(posedge clk) begin
    p_si  <= 25'(cur) * 25'(cfg.inv);
    p_df  <= 25'(fb) * 25'(cfg.factor);
    p_mf  <= 25'(mx) * 25'(cfg.factor);
    sd    <= 16'(cur) * 16'(fb);
    scr   <= 16'(cur) * 16'd255 + 16'(fb) * 16'd255 - 16'(cur) * 16'(fb);
    s1    <= cur;
    mode1 <= cfg.mode;
  end

  assign sum_a = p_si + p_df;
  assign sum_m = p_si + p_mf;
  assign opnd  = (mode1 == pbcg_pkg::MODE_MUL) ? sd : scr;
  assign wide  = 32'(p_si) * 32'd255 + 32'(opnd) * 32'(cfg.factor);

  always_comb begin
    v_next   = {1'b0, s1};
    div_next = 1'b0;
    unique case (mode1)
      pbcg_pkg::MODE_ALPHA: v_next = sum_a[24:16];
      pbcg_pkg::MODE_ADD:   v_next = 9'(s1) + 9'(p_df[24:16]);
      pbcg_pkg::MODE_MUL,
      pbcg_pkg::MODE_SCR:   div_next = 1'b1;
      pbcg_pkg::MODE_MAX:   v_next = sum_m[24:16];
      default:              v_next = {1'b0, s1};
    endcase
  end

  always_ff @(posedge clk) begin
    v2   <= v_next;
    n2   <= wide[31:16];
    div2 <= div_next;
  end

  // divide by 255
  assign q_prod = 32'(n2) * 32'(pbcg_pkg::DIV255_RECIP);
  assign q      = q_prod[31:pbcg_pkg::DIV255_SHIFT];

  always_ff @(posedge clk) begin
    if (div2) begin
      blended <= q[7:0];
    end else begin
      blended <= v2[8] ? 8'hff : v2[7:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/pbcg_luma_merge.sv @@
// merging stage: luma of the three blended lanes, split into quotient and remainder
`timescale 1ns / 1ps
`default_nettype none

module pbcg_luma_merge (
  input  wire logic            clk,
  input  wire logic [2:0][7:0] colour_in,
  output logic      [7:0]      lq,
  output logic      [13:0]     lr,
  output logic      [2:0][7:0] colour_out
);

  logic [21:0]     luma;
  logic [21:0]     luma2;
  logic [44:0]     lq_prod;
  logic [2:0][7:0] c1;
  logic [2:0][7:0] c2;
  logic [7:0]      lq_next;
  logic [21:0]     lr_full;

  always_ff @(posedge clk) begin
    luma <= 22'(colour_in[0]) * 22'(pbcg_pkg::LUM_W_RED)
          + 22'(colour_in[1]) * 22'(pbcg_pkg::LUM_W_GREEN)
          + 22'(colour_in[2]) * 22'(pbcg_pkg::LUM_W_BLUE);
    c1   <= colour_in;
  end

  always_ff @(posedge clk) begin
    lq_prod <= 45'(luma) * 45'(pbcg_pkg::LQ_RECIP);
    luma2   <= luma;
    c2      <= c1;
  end

  assign lq_next = lq_prod[pbcg_pkg::LQ_SHIFT+7:pbcg_pkg::LQ_SHIFT];
  assign lr_full = luma2 - 22'(lq_next) * 22'(pbcg_pkg::LUM_SCALE);

  always_ff @(posedge clk) begin
    lq         <= lq_next;
    lr         <= lr_full[13:0];
    colour_out <= c2;
  end

endmodule

`default_nettype wire

@@ sv/pbcg_grade_lane.sv @@
// one grade lane: saturation, brightness and tint of one colour channel
`timescale 1ns / 1ps
`default_nettype none

module pbcg_grade_lane (
  input  wire logic                 clk,
  input  wire pbcg_pkg::grade_cfg_t cfg,
  input  wire logic [15:0]          tint,
  input  wire logic [7:0]           colour,
  input  wire logic [7:0]           lq,
  input  wire logic [13:0]          lr,
  output logic      [7:0]           graded
);

  logic signed [17:0] k;
  logic        [23:0] xs;
  logic signed [26:0] lqk;
  logic signed [31:0] lrk;

  logic               neg;
  logic        [31:0] mag;
  logic        [30:0] mag_adj;
  logic        [61:0] q_prod;
  logic               neg2;
  logic signed [26:0] base;

  logic        [17:0] q;
  logic signed [26:0] qs;
  logic signed [26:0] a;
  logic        [24:0] a_pos;

  logic        [40:0] b_prod;
  logic        [28:0] b;
  logic        [44:0] c_prod;
  logic        [20:0] hi;

  // weight of luma in the saturation lerp
  assign k = 18'sd4096 - $signed({2'b00, cfg.sat_gain});

  always_ff @(posedge clk) begin
    xs  <= 24'(colour) * 24'(cfg.sat_gain);
    lqk <= $signed({19'd0, lq}) * 27'(k);
    lrk <= $signed({18'd0, lr}) * 32'(k);
  end

  // floor division of the remainder term by the luma scale
  assign neg     = lrk[31];
  assign mag     = neg ? -lrk : lrk;
  assign mag_adj = 31'(mag) + (neg ? 31'(pbcg_pkg::LUM_SCALE - 1) : 31'd0);

  always_ff @(posedge clk) begin
    q_prod <= 62'(mag_adj) * 62'(pbcg_pkg::FRAC_RECIP);
    neg2   <= neg;
    base   <= $signed({3'b000, xs}) + lqk;
  end

  assign q  = q_prod[pbcg_pkg::FRAC_SHIFT+17:pbcg_pkg::FRAC_SHIFT];
  assign qs = $signed({9'd0, q});
  assign a  = base + (neg2 ? -qs : qs);

  always_ff @(posedge clk) begin
    a_pos <= (!a[26] && (a != 27'sd0)) ? a[24:0] : 25'd0;
  end

  assign b_prod = 41'(a_pos) * 41'(cfg.bright_gain);

  always_ff @(posedge clk) begin
    b <= b_prod[40:12];
  end

  assign c_prod = 45'(b) * 45'(tint);
  assign hi     = c_prod[44:24];

  always_ff @(posedge clk) begin
    graded <= (|hi[20:8]) ? 8'hff : hi[7:0];
  end

endmodule

`default_nettype wire
